// File: hw/rtl/traffic_light_controller_unit_assert.svh
// Assertion macros for the traffic light controller unit.
// Used by the checker; expects clk_i and rst_ni in scope.
`ifndef TRAFFIC_LIGHT_CONTROLLER_UNIT_ASSERT_SVH
`define TRAFFIC_LIGHT_CONTROLLER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define TLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tlc_pkg.sv
// Package for the traffic light controller: lamp codes, segment codes,
// state and configuration types, and digit helper functions. No dependencies.
`timescale 1ns / 1ps

package tlc_pkg;

  // Lamp bit positions, from bit 0 up
  localparam int unsigned LampEwRed    = 0;
  localparam int unsigned LampEwYellow = 1;
  localparam int unsigned LampEwGreen  = 2;
  localparam int unsigned LampNsRed    = 3;
  localparam int unsigned LampNsYellow = 4;
  localparam int unsigned LampNsGreen  = 5;

  localparam logic [5:0] LampsPhaseA   = 6'b001100;  // ew green, ns red
  localparam logic [5:0] LampsPhaseB   = 6'b100001;  // ns green, ew red
  localparam logic [5:0] LampsAllRed   = 6'b001001;
  localparam logic [5:0] LampsEwActive = 6'b000110;  // ew green and yellow
  localparam logic [5:0] LampsNsActive = 6'b110000;  // ns green and yellow

  localparam logic [7:0] FlashSecs = 8'd3;

  localparam logic [6:0] SegF     = 7'h71;
  localparam logic [6:0] SegBlank = 7'h00;

  // Configuration register indexes
  localparam logic [2:0] CfgPhaseAFirst  = 3'd0;
  localparam logic [2:0] CfgPhaseASecond = 3'd1;
  localparam logic [2:0] CfgPhaseBFirst  = 3'd2;
  localparam logic [2:0] CfgPhaseBSecond = 3'd3;
  localparam logic [2:0] CfgTicksPerSec  = 3'd4;

  typedef struct packed {
    logic [6:0] pa_first;
    logic [6:0] pa_second;
    logic [6:0] pb_first;
    logic [6:0] pb_second;
    logic [7:0] ticks_per_sec;
  } tlc_cfg_t;

  typedef struct packed {
    logic [7:0] tick;
    logic [7:0] count_first;
    logic [7:0] count_second;
    logic       phase_b;
    logic       flash;
    logic       leaving;
    logic       disp_f;
    logic [5:0] lamps;
  } tlc_state_t;

  // Tens of an 8-bit value by reciprocal multiply, exact below 1029
  function automatic logic [4:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd205;
    return p[15:11];
  endfunction

  // Segment code for one decimal digit; anything above nine is blank
  function automatic logic [6:0] seg_code(input logic [4:0] d);
    logic [6:0] c;
    case (d)
      5'd0: c = 7'h3f;
      5'd1: c = 7'h06;
      5'd2: c = 7'h5b;
      5'd3: c = 7'h4f;
      5'd4: c = 7'h66;
      5'd5: c = 7'h6d;
      5'd6: c = 7'h7d;
      5'd7: c = 7'h07;
      5'd8: c = 7'h7f;
      5'd9: c = 7'h6f;
      default: c = SegBlank;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/traffic_light_controller_unit.sv
// Top level of the traffic light controller: handshakes, configuration
// registers, input and result registers. Depends on tlc_pkg, tlc_state, tlc_seg.
`timescale 1ns / 1ps

// Channel   | Handshake                  | Payload
// in        | in_valid_i / in_ready_o    | emergency_closed_i
// out       | out_valid_o / out_ready_i  | lamps, seg_digit_one..four
// cfg       | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One tick per cycle sustained while the result is not stalled; a tick's result
// becomes valid once its transfer has passed the input register, then the result
// register holding lamps and counts.
// Reset loads the register defaults and phase A; there is no clearing pass.
// A stalled result holds the result register, and the input register takes a
// new tick only when empty or when its held tick moves on. Config is always ready.

module traffic_light_controller_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       emergency_closed_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       ew_red_o,
  output logic       ew_yellow_o,
  output logic       ew_green_o,
  output logic       ns_red_o,
  output logic       ns_yellow_o,
  output logic       ns_green_o,
  output logic [6:0] seg_digit_one_o,
  output logic [6:0] seg_digit_two_o,
  output logic [6:0] seg_digit_three_o,
  output logic [6:0] seg_digit_four_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import tlc_pkg::*;

  tlc_cfg_t   cfg_q;
  tlc_state_t nxt;
  logic       in_valid_q, emerg_q;
  logic       out_valid_q;
  logic       advance, step;
  logic [5:0] lamps_q;
  logic [7:0] count_first_q, count_second_q;
  logic       disp_f_q;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pa_first      <= 7'd20;
      cfg_q.pa_second     <= 7'd23;
      cfg_q.pb_first      <= 7'd13;
      cfg_q.pb_second     <= 7'd10;
      cfg_q.ticks_per_sec <= 8'd20;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgPhaseAFirst:  cfg_q.pa_first      <= cfg_data_i[6:0];
        CfgPhaseASecond: cfg_q.pa_second     <= cfg_data_i[6:0];
        CfgPhaseBFirst:  cfg_q.pb_first      <= cfg_data_i[6:0];
        CfgPhaseBSecond: cfg_q.pb_second     <= cfg_data_i[6:0];
        CfgTicksPerSec:  cfg_q.ticks_per_sec <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the tick on input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      emerg_q <= emergency_closed_i;
    end
  end

  tlc_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .emerg_i (emerg_q),
    .cfg_i   (cfg_q),
    .nxt_o   (nxt)
  );

  // Load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      lamps_q        <= nxt.lamps;
      count_first_q  <= nxt.count_first;
      count_second_q <= nxt.count_second;
      disp_f_q       <= nxt.disp_f;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ew_red_o    = lamps_q[LampEwRed];
  assign ew_yellow_o = lamps_q[LampEwYellow];
  assign ew_green_o  = lamps_q[LampEwGreen];
  assign ns_red_o    = lamps_q[LampNsRed];
  assign ns_yellow_o = lamps_q[LampNsYellow];
  assign ns_green_o  = lamps_q[LampNsGreen];

  // Encode the countdown digits
  tlc_seg u_seg_second (
    .value_i  (count_second_q),
    .show_f_i (disp_f_q),
    .tens_o   (seg_digit_one_o),
    .ones_o   (seg_digit_two_o)
  );

  tlc_seg u_seg_first (
    .value_i  (count_first_q),
    .show_f_i (disp_f_q),
    .tens_o   (seg_digit_three_o),
    .ones_o   (seg_digit_four_o)
  );

endmodule

// File: hw/rtl/tlc_state.sv
// Controller state register and per-tick update: tick counter, countdowns,
// phase, flash and lamps. Depends on tlc_pkg.
`timescale 1ns / 1ps

module tlc_state (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               emerg_i,
  input  tlc_pkg::tlc_cfg_t  cfg_i,
  output tlc_pkg::tlc_state_t nxt_o
);
  import tlc_pkg::*;

  tlc_state_t st_q, st_d;
  logic [7:0] half;

  assign half = {1'b0, cfg_i.ticks_per_sec[7:1]};

  // Compute the state after one tick
  always_comb begin
    st_d = st_q;
    if (emerg_i) begin
      st_d.disp_f       = 1'b1;
      st_d.phase_b      = 1'b0;
      st_d.flash        = 1'b0;
      st_d.lamps        = LampsAllRed;
      st_d.count_first  = {1'b0, cfg_i.pa_first};
      st_d.count_second = {1'b0, cfg_i.pa_second};
      st_d.tick         = 8'd0;
      st_d.leaving      = 1'b1;
    end else begin
      st_d.disp_f = 1'b0;
      st_d.tick   = st_q.tick + 8'd1;
      // restart phase A on release
      if (st_q.leaving) begin
        st_d.lamps   = LampsPhaseA;
        st_d.leaving = 1'b0;
        st_d.tick    = 8'd0;
      end
      // half point: darken the flashing direction
      if (st_d.tick == half && st_d.flash) begin
        if (!st_d.phase_b && st_d.count_second <= FlashSecs) begin
          st_d.lamps = st_d.lamps & ~LampsEwActive;
        end
        if (st_d.phase_b && st_d.count_first <= FlashSecs) begin
          st_d.lamps = st_d.lamps & ~LampsNsActive;
        end
      end
      // second point: advance countdowns
      if (st_d.tick == cfg_i.ticks_per_sec) begin
        st_d.tick         = 8'd0;
        st_d.count_first  = st_d.count_first - 8'd1;
        st_d.count_second = st_d.count_second - 8'd1;
        if (st_d.flash) begin
          if (!st_d.phase_b && st_d.count_second <= FlashSecs) begin
            st_d.lamps[LampEwGreen]  = 1'b0;
            st_d.lamps[LampEwYellow] = 1'b1;
          end
          if (st_d.phase_b && st_d.count_first <= FlashSecs) begin
            st_d.lamps[LampNsGreen]  = 1'b0;
            st_d.lamps[LampNsYellow] = 1'b1;
          end
        end
        if (st_d.count_first == 8'd0 && st_d.count_second == FlashSecs) begin
          st_d.count_first = FlashSecs;
          st_d.flash       = 1'b1;
        end
        if (st_d.count_first == FlashSecs && st_d.count_second == 8'd0) begin
          st_d.count_second = FlashSecs;
          st_d.flash        = 1'b1;
        end
        // both done: change phase
        if (st_d.count_first == 8'd0 && st_d.count_second == 8'd0) begin
          st_d.flash = 1'b0;
          if (!st_d.phase_b) begin
            st_d.phase_b      = 1'b1;
            st_d.lamps        = LampsPhaseB;
            st_d.count_first  = {1'b0, cfg_i.pb_first};
            st_d.count_second = {1'b0, cfg_i.pb_second};
          end else begin
            st_d.phase_b      = 1'b0;
            st_d.lamps        = LampsPhaseA;
            st_d.count_first  = {1'b0, cfg_i.pa_first};
            st_d.count_second = {1'b0, cfg_i.pa_second};
          end
        end
      end
    end
  end

  // Hold state; advance on each processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.tick         <= 8'd0;
      st_q.count_first  <= 8'd20;
      st_q.count_second <= 8'd23;
      st_q.phase_b      <= 1'b0;
      st_q.flash        <= 1'b0;
      st_q.leaving      <= 1'b0;
      st_q.disp_f       <= 1'b0;
      st_q.lamps        <= LampsPhaseA;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  assign nxt_o = st_d;

endmodule

// File: hw/rtl/tlc_seg.sv
// Two-digit seven-segment encoder for one countdown, with the F override.
// Depends on tlc_pkg.
`timescale 1ns / 1ps

module tlc_seg (
  input  logic [7:0] value_i,
  input  logic       show_f_i,
  output logic [6:0] tens_o,
  output logic [6:0] ones_o
);
  import tlc_pkg::*;

  logic [4:0] tens;
  logic [7:0] tens_x10;
  logic [7:0] ones;

  // Split into digits
  assign tens     = div10(value_i);
  assign tens_x10 = {3'd0, tens} * 8'd10;
  assign ones     = value_i - tens_x10;

  // Encode, override with F
  assign tens_o = show_f_i ? SegF : seg_code(tens);
  assign ones_o = show_f_i ? SegF : seg_code(ones[4:0]);

endmodule

// File: hw/rtl/tlc_checker.sv
// Port-level checker for the traffic light controller unit, bound to the top.
// Depends on traffic_light_controller_unit_assert.svh.
`timescale 1ns / 1ps

`include "traffic_light_controller_unit_assert.svh"

module tlc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       emergency_closed_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       ew_red_o,
  input logic       ew_yellow_o,
  input logic       ew_green_o,
  input logic       ns_red_o,
  input logic       ns_yellow_o,
  input logic       ns_green_o,
  input logic [6:0] seg_digit_one_o,
  input logic [6:0] seg_digit_two_o,
  input logic [6:0] seg_digit_three_o,
  input logic [6:0] seg_digit_four_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [2:0] cfg_index_i,
  input logic [7:0] cfg_data_i
);

  // A stalled result stays valid
  `TLC_ASSERT_NEXT(a_out_hold_valid, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

  // A stalled result keeps its lamps and its digits one and four
  `TLC_ASSERT_NEXT(a_out_hold_data, out_valid_o && !out_ready_i, $stable(ew_red_o) && $stable(ew_yellow_o) && $stable(ew_green_o) && $stable(ns_red_o) && $stable(ns_yellow_o) && $stable(ns_green_o) && $stable(seg_digit_one_o) && $stable(seg_digit_four_o), "result changed while stalled")

  // An F display goes with all red
  `TLC_ASSERT(a_emerg_red, !(out_valid_o && seg_digit_one_o == 7'h71) || (ew_red_o && ns_red_o && !ew_green_o && !ns_green_o && !ew_yellow_o && !ns_yellow_o && seg_digit_four_o == 7'h71), "F display without all red")

  // At most one lamp per direction, and some direction holds red
  `TLC_ASSERT(a_lamps_safe, !out_valid_o || ($onehot0({ew_red_o, ew_yellow_o, ew_green_o}) && $onehot0({ns_red_o, ns_yellow_o, ns_green_o}) && (ew_red_o || ns_red_o)), "conflicting lamps")

endmodule

bind traffic_light_controller_unit tlc_checker u_tlc_checker (.*);
